// File: hw/rtl/cnb_pkg.sv
// ----------------------------------------------------------------------------
// cnb_pkg
// Shared codes, constants and controller/datapath signal groups for the
// categorical naive Bayes core.
// ----------------------------------------------------------------------------
`default_nettype none

package cnb_pkg;

  localparam logic [2:0] OP_TRAIN    = 3'd0;
  localparam logic [2:0] OP_PREDICT  = 3'd1;
  localparam logic [2:0] OP_WR_CLASS = 3'd2;
  localparam logic [2:0] OP_WR_VALUE = 3'd3;
  localparam logic [2:0] OP_RD_CLASS = 3'd4;
  localparam logic [2:0] OP_RD_VALUE = 3'd5;
  localparam logic [2:0] OP_CLEAR    = 3'd6;

  localparam logic [1:0] REG_CLASS_COUNT   = 2'd0;
  localparam logic [1:0] REG_FEATURE_COUNT = 2'd1;
  localparam logic [1:0] REG_VALUES        = 2'd2;
  localparam logic [1:0] REG_ALPHA         = 2'd3;

  localparam logic [1:0] LN_Z = 2'd0;
  localparam logic [1:0] LN_C = 2'd1;
  localparam logic [1:0] LN_V = 2'd2;
  localparam logic [1:0] LN_S = 2'd3;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam int          ACC_W   = 40;

  typedef logic [1:0] ln_kind_t;

  typedef struct packed {
    logic     capture;
    logic     sweep;
    logic     rd_mem;
    logic     mem_pred;
    logic     mem_wr;
    logic     cc_wr;
    logic     pend_wr;
    logic     ln_start;
    logic     ln_acc;
    ln_kind_t ln_kind;
    logic     cls_init;
    logic     cls_next;
    logic     feat_init;
    logic     feat_next;
    logic     load_out;
    logic     out_score;
  } cnb_cmd_t;

  typedef struct packed {
    logic       sweep_done;
    logic [2:0] op;
    logic       last;
    logic       k_zero;
    logic       f_end;
    logic       pend_bad;
    logic       cls_last;
    logic       ln_busy;
    logic       ln_done;
  } cnb_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/cnb_if.sv
// ----------------------------------------------------------------------------
// cnb_if
// Request and result channels of the categorical naive Bayes core.
// ----------------------------------------------------------------------------
`default_nettype none

interface cnb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [3:0]  class_label;
  logic [3:0]  feature_index;
  logic [3:0]  feature_value;
  logic        last_feature;
  logic [31:0] count_value;
  modport source (output valid, op, class_label, feature_index, feature_value,
                  last_feature, count_value, input ready);
  modport sink (input valid, op, class_label, feature_index, feature_value,
                last_feature, count_value, output ready);
endinterface

interface cnb_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         class_index;
  logic signed [31:0] score;
  logic [31:0]        count_out;
  logic               last_result;
  modport source (output valid, class_index, score, count_out, last_result,
                  input ready);
  modport sink (input valid, class_index, score, count_out, last_result,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/categorical_naive_bayes_core.sv
// ----------------------------------------------------------------------------
// categorical_naive_bayes_core
// Categorical naive Bayes classifier with additive smoothing.
// ----------------------------------------------------------------------------
// One request at a time. After reset and after a clear request the block
// zeros its count memories in a sweep over MAX_CLASSES*MAX_FEATURES*MAX_VALUES
// entries (4096 by default, rounded up to powers of two) during which no
// request is taken. Count read requests wait for their result to be taken;
// train and count write requests give no result, and a non-final predict
// request only buffers its feature value. The final predict request runs the
// iterative log unit (normalize in byte and bit steps, 16 squaring steps,
// scale) 1 + K*(1 + 2*F') times, where F' is the number of buffered features
// holding a valid value; the log unit sets the scoring time.
// ----------------------------------------------------------------------------
`default_nettype none

module categorical_naive_bayes_core import cnb_pkg::*; #(
  parameter int MAX_CLASSES  = 16,
  parameter int MAX_FEATURES = 16,
  parameter int MAX_VALUES   = 16,
  parameter int COUNT_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  cnb_in_if.sink      in_ch,
  cnb_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cnb_cmd_t cmd;
  cnb_sts_t sts;

  cnb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cnb_datapath #(
    .MAX_CLASSES  (MAX_CLASSES),
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_VALUES   (MAX_VALUES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_ch.op),
    .in_class_label   (in_ch.class_label),
    .in_feature_index (in_ch.feature_index),
    .in_feature_value (in_ch.feature_value),
    .in_last_feature  (in_ch.last_feature),
    .in_count_value   (in_ch.count_value),
    .out_class_index  (out_ch.class_index),
    .out_score        (out_ch.score),
    .out_count_out    (out_ch.count_out),
    .out_last_result  (out_ch.last_result),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata)
  );

  assign cfg_pready = 1'b1;

endmodule

`default_nettype wire

// File: hw/rtl/cnb_ln.sv
// ----------------------------------------------------------------------------
// cnb_ln
// Iterative natural log of a positive Q(XW-16).16 value to signed Q16.16:
// normalize, 16 squaring steps for the log2 fraction, scale by ln2, round.
// ----------------------------------------------------------------------------
`default_nettype none

module cnb_ln import cnb_pkg::*; #(
  parameter int XW = 57
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [XW-1:0]      x,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] result
);

  localparam int EW = $clog2(XW);
  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_NORM = 3'd1;
  localparam logic [2:0] L_SQR  = 3'd2;
  localparam logic [2:0] L_MUL  = 3'd3;
  localparam logic [2:0] L_RND  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [XW-1:0]      m_r, m_nxt;
  logic [EW-1:0]      e_r, e_nxt;
  logic [31:0]        mant_r, mant_nxt;
  logic [15:0]        frac_r, frac_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [55:0]        prod_r, prod_nxt;
  logic               neg_r, neg_nxt;
  logic               done_r, done_nxt;
  logic signed [31:0] result_r, result_nxt;
  logic [63:0]        sq;
  logic signed [7:0]  ei;
  logic signed [23:0] lg;
  logic [23:0]        mag;
  logic [55:0]        rnd;

  always_comb begin
    state_nxt  = state_r;
    m_nxt      = m_r;
    e_nxt      = e_r;
    mant_nxt   = mant_r;
    frac_nxt   = frac_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    neg_nxt    = neg_r;
    done_nxt   = 1'b0;
    result_nxt = result_r;
    sq         = 64'(mant_r) * 64'(mant_r);
    ei         = $signed(8'(e_r)) - 8'sd16;
    lg         = {ei, frac_r};
    mag        = lg[23] ? 24'(-lg) : 24'(lg);
    rnd        = prod_r + 56'h0000_0080_000000;
    case (state_r)
      L_IDLE: begin
        if (start) begin
          m_nxt     = (x == '0) ? XW'(1) : x;
          e_nxt     = EW'(XW - 1);
          state_nxt = L_NORM;
        end
      end
      L_NORM: begin
        if (m_r[XW-1 -: 8] == 8'd0) begin
          m_nxt = m_r << 8;
          e_nxt = e_r - EW'(8);
        end else if (!m_r[XW-1]) begin
          m_nxt = m_r << 1;
          e_nxt = e_r - EW'(1);
        end else begin
          mant_nxt  = m_r[XW-1 -: 32];
          frac_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = L_SQR;
        end
      end
      L_SQR: begin
        if (sq[63]) begin
          mant_nxt = sq[63:32];
          frac_nxt = {frac_r[14:0], 1'b1};
        end else begin
          mant_nxt = sq[62:31];
          frac_nxt = {frac_r[14:0], 1'b0};
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = L_MUL;
        end
      end
      L_MUL: begin
        prod_nxt  = 56'(mag) * 56'(LN2_Q32);
        neg_nxt   = lg[23];
        state_nxt = L_RND;
      end
      L_RND: begin
        result_nxt = neg_r ? -$signed(32'(rnd[55:32])) : $signed(32'(rnd[55:32]));
        done_nxt   = 1'b1;
        state_nxt  = L_IDLE;
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r      <= m_nxt;
    e_r      <= e_nxt;
    mant_r   <= mant_nxt;
    frac_r   <= frac_nxt;
    cnt_r    <= cnt_nxt;
    prod_r   <= prod_nxt;
    neg_r    <= neg_nxt;
    result_r <= result_nxt;
  end

  assign busy   = (state_r != L_IDLE);
  assign done   = done_r;
  assign result = result_r;

endmodule

`default_nettype wire

// File: hw/rtl/cnb_datapath.sv
// ----------------------------------------------------------------------------
// cnb_datapath
// Count storage, configuration registers, log unit, score accumulator and
// result register of the categorical naive Bayes core.
// ----------------------------------------------------------------------------
`default_nettype none

module cnb_datapath import cnb_pkg::*; #(
  parameter int MAX_CLASSES  = 16,
  parameter int MAX_FEATURES = 16,
  parameter int MAX_VALUES   = 16,
  parameter int COUNT_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cnb_cmd_t           cmd,
  output cnb_sts_t           sts,
  input  logic [2:0]         in_op,
  input  logic [3:0]         in_class_label,
  input  logic [3:0]         in_feature_index,
  input  logic [3:0]         in_feature_value,
  input  logic               in_last_feature,
  input  logic [31:0]        in_count_value,
  output logic [3:0]         out_class_index,
  output logic signed [31:0] out_score,
  output logic [31:0]        out_count_out,
  output logic               out_last_result,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata
);

  localparam int CW    = $clog2(MAX_CLASSES);
  localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int VW    = $clog2(MAX_VALUES);
  localparam int KNW   = $clog2(MAX_CLASSES + 1);
  localparam int FNW   = $clog2(MAX_FEATURES + 1);
  localparam int VNW   = $clog2(MAX_VALUES + 1);
  localparam int TW    = COUNT_BITS + CW;
  localparam int SUMW  = COUNT_BITS + VW;
  localparam int VCAW  = CW + FW + VW;
  localparam int FSAW  = CW + FW;
  localparam int XB    = ((TW > SUMW) ? TW : SUMW) + 16;
  localparam int AB    = 32 + ((KNW > VNW) ? KNW : VNW);
  localparam int XW    = ((XB > AB) ? XB : AB) + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [4:0]            class_count_r, feature_count_r, values_r;
  logic [31:0]           alpha_r;
  logic [KNW-1:0]        kc;
  logic [FNW-1:0]        fc;
  logic [VNW-1:0]        vcl;
  logic [31:0]           a_eff;
  logic [KNW+31:0]       ka_r;
  logic [VNW+31:0]       va_r;

  logic [2:0]            op_r;
  logic [3:0]            lab_r, fi_r, val_r;
  logic                  last_r;
  logic [COUNT_BITS-1:0] cv_r;

  logic [FW-1:0]         pos_r, pos_inc;
  logic [COUNT_BITS-1:0] cc_r [MAX_CLASSES];
  logic [TW-1:0]         total_r;
  logic [3:0]            pend_r [MAX_FEATURES];

  logic [COUNT_BITS-1:0] vc_mem [1 << VCAW];
  logic [SUMW-1:0]       fs_mem [1 << FSAW];
  logic [COUNT_BITS-1:0] vc_rd_r;
  logic [SUMW-1:0]       fs_rd_r;
  logic [VCAW-1:0]       sw_r;

  logic [CW-1:0]         c_r;
  logic [FNW-1:0]        f_r;
  logic signed [31:0]    lnz_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [3:0]            out_class_r;
  logic signed [31:0]    out_score_r;
  logic [31:0]           out_count_r;
  logic                  out_last_r;

  logic                  lab_ok, pos_ok, val_ok, fi_ok, tr_inc, wv_ok;
  logic [CW-1:0]         ai_c;
  logic [FW-1:0]         ai_f;
  logic [VW-1:0]         ai_v;
  logic [3:0]            pv;
  logic [VCAW-1:0]       vc_a, vc_wa;
  logic [FSAW-1:0]       fs_a, fs_wa;
  logic                  vc_we, fs_we;
  logic [COUNT_BITS-1:0] vc_wd;
  logic [SUMW-1:0]       fs_wd;
  logic [COUNT_BITS-1:0] cc_lab;
  logic [XW-1:0]         ln_x;
  logic                  ln_busy, ln_done;
  logic signed [31:0]    ln_res;
  logic signed [31:0]    sat;
  logic [ACC_W-32:0]     acc_hi;
  logic [31:0]           cnt_rd;
  logic                  cls_last;

  always_comb begin
    kc    = (32'(class_count_r) > 32'(MAX_CLASSES)) ? KNW'(MAX_CLASSES) : KNW'(class_count_r);
    fc    = (32'(feature_count_r) > 32'(MAX_FEATURES)) ?
            FNW'(MAX_FEATURES) : FNW'(feature_count_r);
    vcl   = (32'(values_r) > 32'(MAX_VALUES)) ? VNW'(MAX_VALUES) : VNW'(values_r);
    a_eff = (alpha_r == 32'd0) ? 32'd1 : alpha_r;
    lab_ok = 32'(lab_r) < 32'(kc);
    pos_ok = 32'(pos_r) < 32'(fc);
    val_ok = 32'(val_r) < 32'(vcl);
    fi_ok  = 32'(fi_r) < 32'(fc);
    pos_inc = (pos_r == FW'(MAX_FEATURES - 1)) ? '0 : pos_r + FW'(1);
    pv     = pend_r[FW'(f_r)];
    cc_lab = cc_r[CW'(lab_r)];
    cls_last = (32'(c_r) + 32'd1) == 32'(kc);

    if (cmd.mem_pred) begin
      ai_c = c_r;
      ai_f = FW'(f_r);
      ai_v = VW'(pv);
    end else begin
      ai_c = CW'(lab_r);
      ai_f = (op_r == OP_TRAIN) ? pos_r : FW'(fi_r);
      ai_v = VW'(val_r);
    end
    vc_a = {ai_c, ai_f, ai_v};
    fs_a = {ai_c, ai_f};

    tr_inc = lab_ok && pos_ok && val_ok && (vc_rd_r != CMAX);
    wv_ok  = lab_ok && fi_ok && val_ok;
    vc_we  = cmd.sweep || (cmd.mem_wr && (((op_r == OP_TRAIN) && tr_inc) ||
                                          ((op_r == OP_WR_VALUE) && wv_ok)));
    fs_we  = vc_we;
    vc_wa  = cmd.sweep ? sw_r : vc_a;
    fs_wa  = cmd.sweep ? FSAW'(sw_r) : fs_a;
    if (cmd.sweep) begin
      vc_wd = '0;
      fs_wd = '0;
    end else if (op_r == OP_TRAIN) begin
      vc_wd = vc_rd_r + COUNT_BITS'(1);
      fs_wd = fs_rd_r + SUMW'(1);
    end else begin
      vc_wd = cv_r;
      fs_wd = fs_rd_r - SUMW'(vc_rd_r) + SUMW'(cv_r);
    end

    case (cmd.ln_kind)
      LN_Z:    ln_x = (XW'(total_r) << 16) + XW'(ka_r);
      LN_C:    ln_x = (XW'(cc_r[c_r]) << 16) + XW'(a_eff);
      LN_V:    ln_x = (XW'(vc_rd_r) << 16) + XW'(a_eff);
      default: ln_x = (XW'(fs_rd_r) << 16) + XW'(va_r);
    endcase

    acc_hi = acc_r[ACC_W-1:31];
    if ((&acc_hi) || !(|acc_hi)) begin
      sat = acc_r[31:0];
    end else begin
      sat = acc_r[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end

    if (op_r == OP_RD_CLASS) begin
      cnt_rd = lab_ok ? 32'(cc_lab) : 32'd0;
    end else begin
      cnt_rd = wv_ok ? 32'(vc_rd_r) : 32'd0;
    end

    case (cfg_paddr[3:2])
      REG_CLASS_COUNT:   cfg_prdata = 32'(class_count_r);
      REG_FEATURE_COUNT: cfg_prdata = 32'(feature_count_r);
      REG_VALUES:        cfg_prdata = 32'(values_r);
      default:           cfg_prdata = alpha_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r   <= 5'd2;
      feature_count_r <= 5'd16;
      values_r        <= 5'd16;
      alpha_r         <= 32'd65536;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[3:2])
        REG_CLASS_COUNT:   class_count_r   <= cfg_pwdata[4:0];
        REG_FEATURE_COUNT: feature_count_r <= cfg_pwdata[4:0];
        REG_VALUES:        values_r        <= cfg_pwdata[4:0];
        default:           alpha_r         <= cfg_pwdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r    <= '0;
      pos_r   <= '0;
      total_r <= '0;
      for (int i = 0; i < MAX_CLASSES; i++) begin
        cc_r[i] <= '0;
      end
    end else begin
      if (cmd.sweep) begin
        sw_r    <= sw_r + VCAW'(1);
        pos_r   <= '0;
        total_r <= '0;
        for (int i = 0; i < MAX_CLASSES; i++) begin
          cc_r[i] <= '0;
        end
      end
      if (cmd.mem_wr && (op_r == OP_TRAIN)) begin
        pos_r <= last_r ? '0 : pos_inc;
        if (last_r && lab_ok && (cc_lab != CMAX)) begin
          cc_r[CW'(lab_r)] <= cc_lab + COUNT_BITS'(1);
          total_r          <= total_r + TW'(1);
        end
      end
      if (cmd.pend_wr) begin
        pos_r <= last_r ? '0 : pos_inc;
      end
      if (cmd.cc_wr && lab_ok) begin
        cc_r[CW'(lab_r)] <= cv_r;
        total_r          <= total_r - TW'(cc_lab) + TW'(cv_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vc_we) begin
      vc_mem[vc_wa] <= vc_wd;
    end
    if (cmd.rd_mem) begin
      vc_rd_r <= vc_mem[vc_a];
    end
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_wa] <= fs_wd;
    end
    if (cmd.rd_mem) begin
      fs_rd_r <= fs_mem[fs_a];
    end
  end

  always_ff @(posedge clk) begin
    ka_r <= (KNW+32)'(kc) * (KNW+32)'(a_eff);
    va_r <= (VNW+32)'(vcl) * (VNW+32)'(a_eff);
    if (cmd.capture) begin
      op_r   <= in_op;
      lab_r  <= in_class_label;
      fi_r   <= in_feature_index;
      val_r  <= in_feature_value;
      last_r <= in_last_feature;
      cv_r   <= (in_count_value > 32'(CMAX)) ? CMAX : COUNT_BITS'(in_count_value);
    end
    if (cmd.pend_wr) begin
      pend_r[pos_r] <= val_r;
    end
    if (cmd.cls_init) begin
      c_r <= '0;
    end else if (cmd.cls_next) begin
      c_r <= c_r + CW'(1);
    end
    if (cmd.feat_init) begin
      f_r <= '0;
    end else if (cmd.feat_next) begin
      f_r <= f_r + FNW'(1);
    end
    if (cmd.ln_acc) begin
      case (cmd.ln_kind)
        LN_Z:    lnz_r <= ln_res;
        LN_C:    acc_r <= ACC_W'(ln_res) - ACC_W'(lnz_r);
        LN_V:    acc_r <= acc_r + ACC_W'(ln_res);
        default: acc_r <= acc_r - ACC_W'(ln_res);
      endcase
    end
    if (cmd.load_out) begin
      if (cmd.out_score) begin
        out_class_r <= 4'(c_r);
        out_score_r <= sat;
        out_count_r <= '0;
        out_last_r  <= cls_last;
      end else begin
        out_class_r <= lab_r;
        out_score_r <= '0;
        out_count_r <= cnt_rd;
        out_last_r  <= 1'b1;
      end
    end
  end

  cnb_ln #(.XW(XW)) u_ln (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.ln_start),
    .x      (ln_x),
    .busy   (ln_busy),
    .done   (ln_done),
    .result (ln_res)
  );

  always_comb begin
    sts.sweep_done = (sw_r == '1);
    sts.op         = op_r;
    sts.last       = last_r;
    sts.k_zero     = (kc == '0);
    sts.f_end      = 32'(f_r) >= 32'(fc);
    sts.pend_bad   = 32'(pv) >= 32'(vcl);
    sts.cls_last   = cls_last;
    sts.ln_busy    = ln_busy;
    sts.ln_done    = ln_done;
  end

  assign out_class_index = out_class_r;
  assign out_score       = out_score_r;
  assign out_count_out   = out_count_r;
  assign out_last_result = out_last_r;

endmodule

`default_nettype wire

// File: hw/rtl/cnb_ctrl.sv
// ----------------------------------------------------------------------------
// cnb_ctrl
// Sequencer of the categorical naive Bayes core: request decode, count
// update steps, clearing sweep and the class/feature scoring loop.
// ----------------------------------------------------------------------------
`default_nettype none

module cnb_ctrl import cnb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  cnb_sts_t sts,
  output cnb_cmd_t cmd
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_MRD  = 4'd3;
  localparam logic [3:0] S_MWR  = 4'd4;
  localparam logic [3:0] S_CWR  = 4'd5;
  localparam logic [3:0] S_PND  = 4'd6;
  localparam logic [3:0] S_RESP = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;
  localparam logic [3:0] S_LNS  = 4'd9;
  localparam logic [3:0] S_LN   = 4'd10;
  localparam logic [3:0] S_FCHK = 4'd11;
  localparam logic [3:0] S_SAT  = 4'd12;

  logic [3:0] state_r, state_nxt;
  ln_kind_t   kind_r, kind_nxt;

  always_comb begin
    cmd         = '0;
    cmd.ln_kind = kind_r;
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    in_ready    = (state_r == S_IDLE);
    out_valid   = (state_r == S_OUT);
    case (state_r)
      S_CLR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.op)
          OP_TRAIN, OP_WR_VALUE, OP_RD_VALUE: state_nxt = S_MRD;
          OP_PREDICT:                         state_nxt = S_PND;
          OP_WR_CLASS:                        state_nxt = S_CWR;
          OP_RD_CLASS:                        state_nxt = S_RESP;
          OP_CLEAR:                           state_nxt = S_CLR;
          default:                            state_nxt = S_IDLE;
        endcase
      end
      S_MRD: begin
        cmd.rd_mem = 1'b1;
        state_nxt  = (sts.op == OP_RD_VALUE) ? S_RESP : S_MWR;
      end
      S_MWR: begin
        cmd.mem_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_CWR: begin
        cmd.cc_wr = 1'b1;
        state_nxt = S_IDLE;
      end
      S_PND: begin
        cmd.pend_wr = 1'b1;
        if (sts.last) begin
          kind_nxt  = LN_Z;
          state_nxt = S_LNS;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LNS: begin
        cmd.ln_start = 1'b1;
        state_nxt    = S_LN;
      end
      S_LN: begin
        if (sts.ln_done) begin
          cmd.ln_acc = 1'b1;
          case (kind_r)
            LN_Z: begin
              cmd.cls_init = 1'b1;
              kind_nxt     = LN_C;
              state_nxt    = sts.k_zero ? S_IDLE : S_LNS;
            end
            LN_C: begin
              cmd.feat_init = 1'b1;
              state_nxt     = S_FCHK;
            end
            LN_V: begin
              kind_nxt  = LN_S;
              state_nxt = S_LNS;
            end
            default: begin
              cmd.feat_next = 1'b1;
              state_nxt     = S_FCHK;
            end
          endcase
        end
      end
      S_FCHK: begin
        if (sts.f_end) begin
          state_nxt = S_SAT;
        end else if (sts.pend_bad) begin
          cmd.feat_next = 1'b1;
        end else begin
          cmd.rd_mem   = 1'b1;
          cmd.mem_pred = 1'b1;
          kind_nxt     = LN_V;
          state_nxt    = S_LNS;
        end
      end
      S_SAT: begin
        cmd.load_out  = 1'b1;
        cmd.out_score = 1'b1;
        state_nxt     = S_OUT;
      end
      S_RESP: begin
        cmd.load_out = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if ((sts.op == OP_PREDICT) && !sts.cls_last) begin
            cmd.cls_next = 1'b1;
            kind_nxt     = LN_C;
            state_nxt    = S_LNS;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      kind_r  <= LN_Z;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ln_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ln_start |-> !sts.ln_busy) else $error("log unit restarted while busy");
  a_ln_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.ln_done |-> (state_r == S_LN)) else $error("log result not awaited");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid) else $error("loaded result not presented");
  a_sweep_whole: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sweep && !sts.sweep_done) |=> cmd.sweep) else $error("clear sweep cut short");
`endif

endmodule

`default_nettype wire
